>>> src/rbmf_pkg.sv
// Shared types and constants of the region box mean filter.
package rbmf_pkg;

    localparam int MAX_ROWS = 1024;
    localparam int ROW_W    = 10;
    localparam int RAD_W    = 3;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_ROW_ORIGIN = 3'd0;
    localparam logic [2:0] REG_COL_ORIGIN = 3'd1;
    localparam logic [2:0] REG_ROWS       = 3'd2;
    localparam logic [2:0] REG_COLS       = 3'd3;
    localparam logic [2:0] REG_RADIUS     = 3'd4;

    // Request codes
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] pixel_value;
    } rbmf_in_t;

    typedef struct packed {
        logic [12:0] out_row;
        logic [12:0] out_col;
        logic [7:0]  mean_value;
        logic        last;
    } rbmf_out_t;

    typedef struct packed {
        logic capture;
        logic store;
        logic check;
        logic walk_step;
        logic div_start;
        logic div_step;
        logic load;
    } rbmf_cmd_t;

    typedef struct packed {
        logic ready;
        logic walk_last;
        logic div_done;
        logic out_free;
    } rbmf_sts_t;

endpackage

>>> src/rbmf_ctrl.sv
// Sequencer of the region box mean filter: steps one word through store, walk and divide.
module rbmf_ctrl import rbmf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  rbmf_sts_t sts,
    output rbmf_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_STORE, ST_CHECK, ST_WALK, ST_FLUSH, ST_DIVS, ST_DIV, ST_OUT
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // Decode commands and next state
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_STORE;
                end
            end
            ST_STORE: begin
                cmd.store  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = sts.ready ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_DIVS;
            end
            ST_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/rbmf_dp.sv
// Datapath of the region box mean filter: line store, position counters, window sum, divider.
module rbmf_dp import rbmf_pkg::*; #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_RADIUS = 3,
    parameter int LINE_ROWS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_wdata,
    input  rbmf_in_t    s_data,
    output rbmf_out_t   m_data,
    output logic        m_valid,
    input  logic        m_ready,
    input  rbmf_cmd_t   cmd,
    output rbmf_sts_t   sts
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int CEW   = CW + 1;
    localparam int LW    = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;
    localparam int AW    = $clog2(LINE_ROWS * MAX_COLS);
    localparam int WIN   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int CNTW  = $clog2(WIN + 1);
    localparam int SUMW  = $clog2(WIN * 255 + 1);
    localparam int ITW   = $clog2(SUMW + 1);
    localparam int DEPTH = LINE_ROWS * MAX_COLS;

    // Configuration registers
    logic [11:0] row_origin_reg, col_origin_reg;
    logic [10:0] rows_reg, cols_reg;
    logic [1:0]  radius_reg;

    // Stream position
    logic [ROW_W-1:0] in_row_reg, out_row_reg;
    logic [CW-1:0]    in_col_reg, out_col_reg;
    logic [LW-1:0]    in_line_reg, out_line_reg;
    logic             done_reg;

    // Captured word
    rbmf_in_t item_reg;

    // Window walk
    logic [ROW_W-1:0] y_reg, y_end_reg;
    logic [CW-1:0]    x_reg, x_begin_reg, x_end_reg;
    logic [LW-1:0]    wline_reg;
    logic             rd_valid_reg;
    logic [7:0]       mem_q_reg;
    logic [SUMW-1:0]  sum_reg;
    logic [CNTW-1:0]  cnt_reg;

    // Divider
    logic [SUMW-1:0]  quo_reg;
    logic [CNTW:0]    rem_reg;
    logic [ITW-1:0]   iter_reg;

    // Output register
    rbmf_out_t m_data_reg;
    logic      m_valid_reg;

    logic [7:0] mem [DEPTH];

    // Effective sizes
    logic [10:0]      rows_eff;
    logic [CEW-1:0]   cols_eff;
    logic [RAD_W-1:0] rad_eff;
    logic [12:0]      cols_w;

    always_comb begin
        cols_w   = 13'(cols_reg);
        rows_eff = (rows_reg == 11'd0) ? 11'd1 :
                   ((rows_reg > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : rows_reg);
        cols_eff = (cols_w == 13'd0) ? CEW'(1) :
                   ((cols_w > 13'(MAX_COLS)) ? CEW'(MAX_COLS) : CEW'(cols_w));
        rad_eff  = (RAD_W'(radius_reg) > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS)
                                                              : RAD_W'(radius_reg);
    end

    // Window bounds and readiness
    logic [10:0]      lr, lr_raw, in_row_w;
    logic [CEW-1:0]   lc, lc_raw;
    logic [ROW_W-1:0] r0;
    logic [CW-1:0]    c0;
    logic [RAD_W-1:0] k;
    logic [LW+1:0]    t0, t1, t2;
    logic             win_ready;

    always_comb begin
        lr_raw   = 11'(out_row_reg) + 11'(rad_eff);
        lr       = (lr_raw > rows_eff - 11'd1) ? rows_eff - 11'd1 : lr_raw;
        lc_raw   = CEW'(out_col_reg) + CEW'(rad_eff);
        lc       = (lc_raw > cols_eff - CEW'(1)) ? cols_eff - CEW'(1) : lc_raw;
        r0       = (out_row_reg >= ROW_W'(rad_eff)) ? out_row_reg - ROW_W'(rad_eff) : '0;
        c0       = (CEW'(out_col_reg) >= CEW'(rad_eff)) ?
                   CW'(CEW'(out_col_reg) - CEW'(rad_eff)) : '0;
        k        = RAD_W'(out_row_reg - r0);
        in_row_w = 11'(in_row_reg);
        win_ready = done_reg || (in_row_w > lr) ||
                    ((in_row_w == lr) && (CEW'(in_col_reg) > lc));
        // line of the top window row, wrapped into the line store
        t0 = (LW+2)'(out_line_reg) + (LW+2)'(2 * LINE_ROWS) - (LW+2)'(k);
        t1 = (t0 >= (LW+2)'(2 * LINE_ROWS)) ? t0 - (LW+2)'(2 * LINE_ROWS) : t0;
        t2 = (t1 >= (LW+2)'(LINE_ROWS)) ? t1 - (LW+2)'(LINE_ROWS) : t1;
    end

    logic out_last;
    assign out_last = (11'(out_row_reg) + 11'd1 >= rows_eff) &&
                      (CEW'(out_col_reg) + CEW'(1) >= cols_eff);

    logic [CNTW:0] rem_sh;
    assign rem_sh = {rem_reg[CNTW-1:0], quo_reg[SUMW-1]};

    assign sts.ready     = win_ready;
    assign sts.walk_last = (x_reg == x_end_reg) && (y_reg == y_end_reg);
    assign sts.div_done  = (iter_reg == '0);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_data  = m_data_reg;
    assign m_valid = m_valid_reg;

    // Line store write and registered read
    logic [AW-1:0] wr_addr, rd_addr;
    logic          wr_en;
    assign wr_addr = AW'(in_line_reg) * AW'(MAX_COLS) + AW'(in_col_reg);
    assign rd_addr = AW'(wline_reg) * AW'(MAX_COLS) + AW'(x_reg);
    assign wr_en   = cmd.store && (item_reg.req_type == REQ_PUSH) && !done_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= item_reg.pixel_value;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Capture word, walk the window, accumulate, divide
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.check) begin
            y_reg       <= r0;
            y_end_reg   <= ROW_W'(lr);
            x_reg       <= c0;
            x_begin_reg <= c0;
            x_end_reg   <= CW'(lc);
            wline_reg   <= LW'(t2);
            sum_reg     <= '0;
            cnt_reg     <= '0;
        end else begin
            if (cmd.walk_step) begin
                if (x_reg == x_end_reg) begin
                    x_reg     <= x_begin_reg;
                    y_reg     <= y_reg + ROW_W'(1);
                    wline_reg <= (wline_reg == LW'(LINE_ROWS - 1)) ? '0 : wline_reg + LW'(1);
                end else begin
                    x_reg <= x_reg + CW'(1);
                end
            end
            if (rd_valid_reg) begin
                sum_reg <= sum_reg + SUMW'(mem_q_reg);
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
        if (cmd.div_start) begin
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            iter_reg <= ITW'(SUMW);
        end else if (cmd.div_step) begin
            if (rem_sh >= (CNTW+1)'(cnt_reg)) begin
                rem_reg <= rem_sh - (CNTW+1)'(cnt_reg);
                quo_reg <= {quo_reg[SUMW-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[SUMW-2:0], 1'b0};
            end
            iter_reg <= iter_reg - ITW'(1);
        end
        if (cmd.load) begin
            m_data_reg.out_row    <= 13'(row_origin_reg) + 13'(out_row_reg);
            m_data_reg.out_col    <= 13'(col_origin_reg) + 13'(out_col_reg);
            m_data_reg.mean_value <= quo_reg[7:0];
            m_data_reg.last       <= out_last;
        end
    end

    // Control state: configuration, positions, valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_origin_reg <= '0;
            col_origin_reg <= '0;
            rows_reg       <= 11'd1;
            cols_reg       <= 11'd1;
            radius_reg     <= 2'd1;
            in_row_reg     <= '0;
            in_col_reg     <= '0;
            in_line_reg    <= '0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_line_reg   <= '0;
            done_reg       <= 1'b0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.walk_step;
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROW_ORIGIN: row_origin_reg <= cfg_wdata;
                    REG_COL_ORIGIN: col_origin_reg <= cfg_wdata;
                    REG_ROWS:       rows_reg       <= cfg_wdata[10:0];
                    REG_COLS:       cols_reg       <= cfg_wdata[10:0];
                    REG_RADIUS:     radius_reg     <= cfg_wdata[1:0];
                    default:        ;
                endcase
            end
            if (cfg_we || (cmd.load && out_last)) begin
                // restart the region stream
                in_row_reg   <= '0;
                in_col_reg   <= '0;
                in_line_reg  <= '0;
                out_row_reg  <= '0;
                out_col_reg  <= '0;
                out_line_reg <= '0;
                done_reg     <= 1'b0;
            end else begin
                if (wr_en) begin
                    if (CEW'(in_col_reg) + CEW'(1) >= cols_eff) begin
                        if (11'(in_row_reg) + 11'd1 >= rows_eff) begin
                            done_reg <= 1'b1;
                        end else begin
                            in_col_reg  <= '0;
                            in_row_reg  <= in_row_reg + ROW_W'(1);
                            in_line_reg <= (in_line_reg == LW'(LINE_ROWS - 1)) ? '0
                                           : in_line_reg + LW'(1);
                        end
                    end else begin
                        in_col_reg <= in_col_reg + CW'(1);
                    end
                end
                if (cmd.load) begin
                    if (CEW'(out_col_reg) + CEW'(1) >= cols_eff) begin
                        out_col_reg  <= '0;
                        out_row_reg  <= out_row_reg + ROW_W'(1);
                        out_line_reg <= (out_line_reg == LW'(LINE_ROWS - 1)) ? '0
                                        : out_line_reg + LW'(1);
                    end else begin
                        out_col_reg <= out_col_reg + CW'(1);
                    end
                end
            end
            if (cmd.load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> src/roi_clipped_box_mean_filter.sv
// Top level of the region box mean filter: sequencer plus datapath.
// A word that releases no result passes through accept, store and readiness
// check. A word that releases a result then reads its window from the line
// store one pixel per cycle (1 to (2*MAX_RADIUS+1)^2 pixels) and runs a
// restoring divider one quotient bit per cycle (14 steps). Loading the result
// into the output register waits while that register still holds a result
// not yet accepted with m_ready. The next word is
// taken while a finished result still waits in the output register.
module roi_clipped_box_mean_filter import rbmf_pkg::*; #(
    parameter int MAX_COLS   = 1024,
    parameter int MAX_RADIUS = 3,
    parameter int LINE_ROWS  = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  rbmf_in_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output rbmf_out_t   m_data
);

    rbmf_cmd_t cmd;
    rbmf_sts_t sts;

    rbmf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rbmf_dp #(
        .MAX_COLS   (MAX_COLS),
        .MAX_RADIUS (MAX_RADIUS),
        .LINE_ROWS  (LINE_ROWS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
